/* hw/rtl/websocket_frame_deframer_unmask_core_defines.svh */
// Assertion helpers for the deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_CORE_DEFINES_SVH

// same-cycle implication
`define WSDFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsdfr assertion failed");

// next-cycle implication
`define WSDFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsdfr assertion failed");

`endif

/* hw/rtl/wsdfr_pkg.sv */
`default_nettype none
package wsdfr_pkg;

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [1:0] KEY_LAST_POS = 2'd3;

	typedef enum logic [2:0] {
		PH_HEAD0   = 3'd0,
		PH_HEAD1   = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// front to back: one payload byte or an empty-frame marker
	typedef struct packed {
		logic [7:0]  data;
		logic [7:0]  key;
		logic        last;
		logic        empty;
		logic [63:0] length;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic        empty_frame;
		logic [63:0] payload_len;
	} res_t;

endpackage
`default_nettype wire

/* hw/rtl/wsdfr_fifo.sv */
`default_nettype none
module wsdfr_fifo #(
	parameter int DEPTH = wsdfr_pkg::CMD_DEPTH,
	parameter type word_t = wsdfr_pkg::cmd_t
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  wire word_t wr_word,
	output logic       full,
	input  wire        pop,
	output word_t      rd_word,
	output logic       empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	word_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/wsdfr_front.sv */
`default_nettype none
module wsdfr_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              accept,
	input  wire        [7:0] frame_byte,
	output logic             cmd_push,
	output wsdfr_pkg::cmd_t  cmd
);
	import wsdfr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  ext_q, ext_d;
	logic [63:0] len_q, len_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  pos_q, pos_d;
	logic        emit;
	logic        last_byte;
	logic [7:0]  key_byte;

	always_comb begin
		unique case (pos_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
		endcase
	end

	assign last_byte = (rem_q == 64'd1);

	always_comb begin
		phase_d = phase_q;
		ext_d   = ext_q;
		len_d   = len_q;
		rem_d   = rem_q;
		key_d   = key_q;
		pos_d   = pos_q;
		emit    = 1'b0;
		cmd     = '0;
		unique case (phase_q)
			PH_HEAD1: begin
				pos_d = '0;
				key_d = '0;
				if (frame_byte[6:0] == LEN_EXT16) begin
					len_d   = '0;
					ext_d   = EXT16_BYTES;
					phase_d = PH_EXTLEN;
				end else if (frame_byte[6:0] == LEN_EXT64) begin
					len_d   = '0;
					ext_d   = EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					len_d   = {57'd0, frame_byte[6:0]};
					ext_d   = '0;
					phase_d = PH_KEY;
				end
			end
			PH_EXTLEN: begin
				len_d = {len_q[55:0], frame_byte};
				ext_d = ext_q - 1'b1;
				if (ext_q == 4'd1) begin
					phase_d = PH_KEY;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], frame_byte};
				if (pos_q == KEY_LAST_POS) begin
					pos_d = '0;
					if (len_q == '0) begin
						rem_d     = '0;
						phase_d   = PH_HEAD0;
						emit      = 1'b1;
						cmd.last  = 1'b1;
						cmd.empty = 1'b1;
					end else begin
						rem_d   = len_q;
						phase_d = PH_PAYLOAD;
					end
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end
			PH_PAYLOAD: begin
				pos_d      = pos_q + 1'b1;
				rem_d      = rem_q - 64'd1;
				emit       = 1'b1;
				cmd.data   = frame_byte;
				cmd.key    = key_byte;
				cmd.last   = last_byte;
				cmd.length = last_byte ? len_q : '0;
				if (last_byte) begin
					phase_d = PH_HEAD0;
				end
			end
			default: begin
				phase_d = PH_HEAD1;
			end
		endcase
	end

	assign cmd_push = accept & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD0;
			ext_q   <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			key_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			ext_q   <= ext_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			key_q   <= key_d;
			pos_q   <= pos_d;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/wsdfr_back.sv */
`default_nettype none
module wsdfr_back (
	input  wire                  cmd_valid,
	input  wire wsdfr_pkg::cmd_t cmd,
	output logic                 cmd_pop,
	input  wire                  res_full,
	output logic                 res_push,
	output wsdfr_pkg::res_t      res
);
	import wsdfr_pkg::*;

	assign cmd_pop  = cmd_valid & ~res_full;
	assign res_push = cmd_pop;

	always_comb begin
		res.payload_byte  = cmd.empty ? 8'd0 : (cmd.data ^ cmd.key);
		res.last_of_frame = cmd.last;
		res.empty_frame   = cmd.empty;
		res.payload_len   = cmd.last ? cmd.length : 64'd0;
	end
endmodule
`default_nettype wire

/* hw/rtl/websocket_frame_deframer_unmask_core.sv */
// A payload word passes the command queue, then the result queue, to reach the result ports.
// One byte per cycle unless stalled; only payload bytes and empty-frame markers give words.
// Input stalls only while the command queue is full; the result queue parts both sides.
// Reset (arst_n low, asynchronous): frame parser back to first header byte, both queues empty.
`default_nettype none
`include "websocket_frame_deframer_unmask_core_defines.svh"
module websocket_frame_deframer_unmask_core #(
	parameter int CMD_DEPTH = wsdfr_pkg::CMD_DEPTH,
	parameter int RES_DEPTH = wsdfr_pkg::RES_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [7:0]  frame_byte,
	input  wire         pop,
	output logic        empty,
	output logic [7:0]  payload_byte,
	output logic        last_of_frame,
	output logic        empty_frame,
	output logic [63:0] payload_len
);
	import wsdfr_pkg::*;

	logic accept;
	logic cmd_push, cmd_full, cmd_empty, cmd_pop;
	cmd_t cmd_in, cmd_out;
	logic res_push, res_full;
	res_t res_in, res_out;

	assign full   = cmd_full;
	assign accept = push & ~cmd_full;

	wsdfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (frame_byte),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	wsdfr_fifo #(.DEPTH(CMD_DEPTH), .word_t(cmd_t)) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_word (cmd_in),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_word (cmd_out),
		.empty   (cmd_empty)
	);

	wsdfr_back u_back (
		.cmd_valid (~cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	wsdfr_fifo #(.DEPTH(RES_DEPTH), .word_t(res_t)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_word (res_in),
		.full    (res_full),
		.pop     (pop),
		.rd_word (res_out),
		.empty   (empty)
	);

	assign payload_byte  = res_out.payload_byte;
	assign last_of_frame = res_out.last_of_frame;
	assign empty_frame   = res_out.empty_frame;
	assign payload_len   = res_out.payload_len;

	`WSDFR_ASSERT_NOW(a_marker_form, !empty && empty_frame, last_of_frame && payload_byte == 8'd0 && payload_len == 64'd0)
	`WSDFR_ASSERT_NOW(a_len_only_last, !empty && !last_of_frame, payload_len == 64'd0)
	`WSDFR_ASSERT_NEXT(a_word_reaches_out, res_push, !empty)
	`WSDFR_ASSERT_NEXT(a_cmd_lands, cmd_push, !cmd_empty)
endmodule
`default_nettype wire
